/* design/rlt_pkg.sv */
// ----------------------------------------------------------------------------
// rlt_pkg
// Shared constants, operation and result codes, and the controller/datapath
// command and status types of the range lock table.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int CELLS_DEF      = 64;
    localparam int LEVELS_DEF     = 2;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int RANGE_BITS_DEF = 48;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OP_W        = 3;
    localparam int SLOT_PORT_W = 6;
    localparam int DEV_W       = 24;
    localparam int BIO_W       = 16;
    localparam int TAG_W       = 8;
    localparam int CODE_W      = 3;

    localparam logic [OP_W-1:0] OP_GET     = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
    localparam logic [OP_W-1:0] OP_LOCK    = 3'd2;
    localparam logic [OP_W-1:0] OP_QUIESCE = 3'd3;
    localparam logic [OP_W-1:0] OP_PROMOTE = 3'd4;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd5;

    localparam logic [CODE_W-1:0] RC_GRANTED  = 3'd0;
    localparam logic [CODE_W-1:0] RC_PARKED   = 3'd1;
    localparam logic [CODE_W-1:0] RC_BUSY     = 3'd2;
    localparam logic [CODE_W-1:0] RC_NOT_EXCL = 3'd3;
    localparam logic [CODE_W-1:0] RC_FULL     = 3'd4;
    localparam logic [CODE_W-1:0] RC_SHARED   = 3'd5;
    localparam logic [CODE_W-1:0] RC_OVERFLOW = 3'd6;
    localparam logic [CODE_W-1:0] RC_BAD      = 3'd7;

    typedef struct packed {
        logic cap_en;
        logic cmp_en;
        logic sel_en;
        logic rd_en;
        logic exe_en;
        logic drn_rd;
        logic drn_emit;
    } rlt_cmd_t;

    typedef struct packed {
        logic out_free;
        logic exe_drain;
        logic drain_last;
    } rlt_stat_t;

endpackage

/* design/range_lock_table.sv */
// ----------------------------------------------------------------------------
// range_lock_table
// Lock table keyed by (virtual flag, device, half-open block range).
//
// Input channel (in_valid/in_stall): one operation per transfer. in_stall is
// high from the transfer until the operation has executed and its released tags are emitted;
// the next item is taken while its predecessor's result still sits in the output register.
// Output channel (out_valid/out_stall): one result per transfer, last marks
// the final result of an item. Unlock gives one result per parked tag, or a single result if none is parked.
// The result is registered after the overlap compare over all slots, slot
// select, record RAM read and execute states. A new item is not taken until
// the previous one has executed and emitted its released tags; unlock with
// parked tags adds one parked RAM read plus one emit per tag. The compare,
// select and record RAM read-modify-write stages are not overlapped between items.
// Reset: all slots free; no clearing pass is needed.
// A stalled output holds its result and the sequencer waits before executing
// the next item or emitting the next released tag.
// ----------------------------------------------------------------------------
module range_lock_table
    import rlt_pkg::*;
#(
    parameter int CELLS      = CELLS_DEF,
    parameter int LEVELS     = LEVELS_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int RANGE_BITS = RANGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [OP_W-1:0]        op,
    input  logic                   key_virtual,
    input  logic [DEV_W-1:0]       key_dev,
    input  logic [RANGE_BITS-1:0]  range_begin,
    input  logic [RANGE_BITS-1:0]  range_end,
    input  logic                   hold_level,
    input  logic [BIO_W-1:0]       bio_tag,
    input  logic [SLOT_PORT_W-1:0] cell_slot_in,
    input  logic [TAG_W-1:0]       continuation_tag,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CODE_W-1:0]      result_code,
    output logic [SLOT_PORT_W-1:0] cell_slot,
    output logic                   cell_freed,
    output logic                   released_valid,
    output logic [BIO_W-1:0]       released_bio,
    output logic                   fired_valid,
    output logic [TAG_W-1:0]       fired_tag,
    output logic                   last
);

    rlt_cmd_t  cmd;
    rlt_stat_t stat;

    rlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rlt_dp #(
        .CELLS      (CELLS),
        .LEVELS     (LEVELS),
        .WAIT_DEPTH (WAIT_DEPTH),
        .RANGE_BITS (RANGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .op               (op),
        .key_virtual      (key_virtual),
        .key_dev          (key_dev),
        .range_begin      (range_begin),
        .range_end        (range_end),
        .hold_level       (hold_level),
        .bio_tag          (bio_tag),
        .cell_slot_in     (cell_slot_in),
        .continuation_tag (continuation_tag),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_code      (result_code),
        .cell_slot        (cell_slot),
        .cell_freed       (cell_freed),
        .released_valid   (released_valid),
        .released_bio     (released_bio),
        .fired_valid      (fired_valid),
        .fired_tag        (fired_tag),
        .last             (last)
    );

endmodule

/* design/rlt_ram.sv */
// ----------------------------------------------------------------------------
// rlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/rlt_ctrl.sv */
// ----------------------------------------------------------------------------
// rlt_ctrl
// Sequencer: capture, compare, select, record read, execute, then one
// read/emit pair per released parked tag.
// ----------------------------------------------------------------------------
module rlt_ctrl
    import rlt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  rlt_stat_t stat,
    output rlt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EXE  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DEM  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_en = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_en = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                cmd.sel_en = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EXE;
            end
            S_EXE:
            begin
                if (stat.out_free)
                begin
                    cmd.exe_en = 1'b1;
                    state_next = stat.exe_drain ? S_DRD : S_IDLE;
                end
            end
            S_DRD:
            begin
                cmd.drn_rd = 1'b1;
                state_next = S_DEM;
            end
            S_DEM:
            begin
                if (stat.out_free)
                begin
                    cmd.drn_emit = 1'b1;
                    state_next   = stat.drain_last ? S_IDLE : S_DRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

/* design/rlt_dp.sv */
// ----------------------------------------------------------------------------
// rlt_dp
// Datapath: key store with parallel overlap compare, slot record RAM,
// parked tag RAM and the result register.
// ----------------------------------------------------------------------------
module rlt_dp
    import rlt_pkg::*;
#(
    parameter int CELLS      = CELLS_DEF,
    parameter int LEVELS     = LEVELS_DEF,
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int RANGE_BITS = RANGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rlt_cmd_t               cmd,
    output rlt_stat_t              stat,
    input  logic [OP_W-1:0]        op,
    input  logic                   key_virtual,
    input  logic [DEV_W-1:0]       key_dev,
    input  logic [RANGE_BITS-1:0]  range_begin,
    input  logic [RANGE_BITS-1:0]  range_end,
    input  logic                   hold_level,
    input  logic [BIO_W-1:0]       bio_tag,
    input  logic [SLOT_PORT_W-1:0] cell_slot_in,
    input  logic [TAG_W-1:0]       continuation_tag,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CODE_W-1:0]      result_code,
    output logic [SLOT_PORT_W-1:0] cell_slot,
    output logic                   cell_freed,
    output logic                   released_valid,
    output logic [BIO_W-1:0]       released_bio,
    output logic                   fired_valid,
    output logic [TAG_W-1:0]       fired_tag,
    output logic                   last
);

    localparam int SLOT_W = $clog2(CELLS);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PC_W   = $clog2(WAIT_DEPTH + 1);
    localparam int PA_W   = $clog2(CELLS * WAIT_DEPTH);

    typedef struct packed {
        logic [LEVELS-1:0][COUNT_BITS-1:0] holders;
        logic                              excl;
        logic [LVL_W-1:0]                  xlvl;
        logic                              qp;
        logic [TAG_W-1:0]                  qtag;
        logic [PC_W-1:0]                   pcnt;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // captured item
    logic [OP_W-1:0]        op_reg;
    logic                   kv_reg;
    logic [DEV_W-1:0]       kd_reg;
    logic [RANGE_BITS-1:0]  kb_reg;
    logic [RANGE_BITS-1:0]  ke_reg;
    logic                   lvl_reg;
    logic [BIO_W-1:0]       bio_reg;
    logic [SLOT_PORT_W-1:0] sin_reg;
    logic [TAG_W-1:0]       cont_reg;

    // key store
    logic                  valid_reg [CELLS];
    logic                  valid_next [CELLS];
    logic                  key_v_reg [CELLS];
    logic [DEV_W-1:0]      key_d_reg [CELLS];
    logic [RANGE_BITS-1:0] key_b_reg [CELLS];
    logic [RANGE_BITS-1:0] key_e_reg [CELLS];

    logic [CELLS-1:0] match_reg;
    logic [CELLS-1:0] match_next;

    logic              hit_reg;
    logic              free_ok_reg;
    logic              sin_ok_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              hit_next;
    logic              free_ok_next;
    logic              sin_ok_next;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] slot_next;
    logic              key_op;

    // record and parked RAM ports
    logic [REC_W-1:0] rec_rdata;
    logic [BIO_W-1:0] park_rdata;
    logic             rec_we;
    logic             park_we;
    logic [PA_W-1:0]  park_waddr;
    logic [PA_W-1:0]  park_raddr;
    rec_t             rec;
    rec_t             rec_w;
    rec_t             fresh;

    // execute results
    logic [CODE_W-1:0]      e_code;
    logic [SLOT_PORT_W-1:0] e_slot;
    logic                   e_freed;
    logic                   e_fv;
    logic [TAG_W-1:0]       e_ft;
    logic                   e_drain;
    logic [PC_W-1:0]        e_n;
    logic                   e_alloc;
    logic                   e_clr;
    logic [LVL_W-1:0]       li;
    logic                   lvl_bad;

    // drain
    logic [PC_W-1:0] didx_reg;
    logic [PC_W-1:0] dcnt_reg;
    logic            freed_reg;

    // result register
    logic                   out_valid_reg;
    logic [CODE_W-1:0]      code_reg;
    logic [SLOT_PORT_W-1:0] oslot_reg;
    logic                   ofreed_reg;
    logic                   rv_reg;
    logic [BIO_W-1:0]       rb_reg;
    logic                   fv_reg;
    logic [TAG_W-1:0]       ft_reg;
    logic                   last_reg;

    function automatic logic none_upto(rec_t r, logic [LVL_W-1:0] lv);
        logic res;
        res = 1'b1;
        for (int l = 0; l < LEVELS; l++)
        begin
            if ((l <= 32'(lv)) && (r.holders[l] != '0))
            begin
                res = 1'b0;
            end
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            op_reg   <= op;
            kv_reg   <= key_virtual;
            kd_reg   <= key_dev;
            kb_reg   <= range_begin;
            ke_reg   <= range_end;
            lvl_reg  <= hold_level;
            bio_reg  <= bio_tag;
            sin_reg  <= cell_slot_in;
            cont_reg <= continuation_tag;
        end
    end

    always_comb
    begin
        for (int s = 0; s < CELLS; s++)
        begin
            match_next[s] = valid_reg[s] && (key_v_reg[s] == kv_reg) &&
                            (key_d_reg[s] == kd_reg) && (kb_reg < key_e_reg[s]) &&
                            (key_b_reg[s] < ke_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_en)
        begin
            match_reg <= match_next;
        end
    end

    always_comb
    begin
        hit_next     = 1'b0;
        free_ok_next = 1'b0;
        hit_slot     = '0;
        free_slot    = '0;
        for (int s = CELLS - 1; s >= 0; s--)
        begin
            if (match_reg[s])
            begin
                hit_next = 1'b1;
                hit_slot = SLOT_W'(s);
            end
            if (!valid_reg[s])
            begin
                free_ok_next = 1'b1;
                free_slot    = SLOT_W'(s);
            end
        end
        key_op      = (op_reg == OP_GET) || (op_reg == OP_LOCK);
        sin_ok_next = (32'(sin_reg) < 32'(CELLS)) && valid_reg[SLOT_W'(sin_reg)];
        if (key_op)
        begin
            slot_next = hit_next ? hit_slot : free_slot;
        end
        else
        begin
            slot_next = SLOT_W'(sin_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel_en)
        begin
            hit_reg     <= hit_next;
            free_ok_reg <= free_ok_next;
            sin_ok_reg  <= sin_ok_next;
            slot_reg    <= slot_next;
        end
    end

    rlt_ram #(
        .WIDTH (REC_W),
        .DEPTH (CELLS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (slot_reg),
        .wdata (rec_w),
        .re    (cmd.rd_en),
        .raddr (slot_reg),
        .rdata (rec_rdata)
    );

    assign park_waddr = PA_W'(slot_reg) * PA_W'(WAIT_DEPTH) + PA_W'(rec.pcnt);
    assign park_raddr = PA_W'(slot_reg) * PA_W'(WAIT_DEPTH) + PA_W'(didx_reg);

    rlt_ram #(
        .WIDTH (BIO_W),
        .DEPTH (CELLS * WAIT_DEPTH)
    ) u_park_ram (
        .clk   (clk),
        .we    (park_we),
        .waddr (park_waddr),
        .wdata (bio_reg),
        .re    (cmd.drn_rd),
        .raddr (park_raddr),
        .rdata (park_rdata)
    );

    always_comb
    begin
        rec     = rec_t'(rec_rdata);
        fresh   = '0;
        rec_w   = rec;
        e_code  = RC_GRANTED;
        e_slot  = SLOT_PORT_W'(slot_reg);
        e_freed = 1'b0;
        e_fv    = 1'b0;
        e_ft    = '0;
        e_drain = 1'b0;
        e_n     = '0;
        e_alloc = 1'b0;
        e_clr   = 1'b0;
        rec_we  = 1'b0;
        park_we = 1'b0;
        li      = LVL_W'(lvl_reg);
        lvl_bad = (32'(lvl_reg) >= 32'(LEVELS));
        if (op_reg > OP_UNLOCK)
        begin
            e_code = RC_BAD;
            e_slot = '0;
        end
        else if ((op_reg == OP_GET) || (op_reg == OP_LOCK))
        begin
            if (lvl_bad)
            begin
                e_code = RC_BAD;
                e_slot = '0;
            end
            else if (hit_reg)
            begin
                if (op_reg == OP_GET)
                begin
                    if (rec.excl && (li <= rec.xlvl))
                    begin
                        if (32'(rec.pcnt) >= 32'(WAIT_DEPTH))
                        begin
                            e_code = RC_OVERFLOW;
                        end
                        else
                        begin
                            park_we    = 1'b1;
                            rec_w.pcnt = rec.pcnt + PC_W'(1);
                            rec_we     = 1'b1;
                            e_code     = RC_PARKED;
                        end
                    end
                    else if (rec.holders[li] == '1)
                    begin
                        e_code = RC_OVERFLOW;
                    end
                    else
                    begin
                        rec_w.holders[li] = rec.holders[li] + COUNT_BITS'(1);
                        rec_we            = 1'b1;
                    end
                end
                else if (rec.excl)
                begin
                    e_code = RC_BUSY;
                end
                else
                begin
                    rec_w.excl = 1'b1;
                    rec_w.xlvl = li;
                    rec_we     = 1'b1;
                    e_code     = none_upto(rec, li) ? RC_GRANTED : RC_SHARED;
                end
            end
            else if (!free_ok_reg)
            begin
                e_code = RC_FULL;
                e_slot = '0;
            end
            else
            begin
                e_alloc = 1'b1;
                rec_we  = 1'b1;
                rec_w   = fresh;
                if (op_reg == OP_GET)
                begin
                    rec_w.holders[li] = COUNT_BITS'(1);
                end
                else
                begin
                    rec_w.excl = 1'b1;
                    rec_w.xlvl = li;
                end
            end
        end
        else if (!sin_ok_reg)
        begin
            e_code = RC_BAD;
            e_slot = sin_reg;
        end
        else if (op_reg == OP_PUT)
        begin
            if (lvl_bad || (rec.holders[li] == '0))
            begin
                e_code = RC_BAD;
            end
            else
            begin
                rec_w.holders[li] = rec.holders[li] - COUNT_BITS'(1);
                rec_we            = 1'b1;
                if (rec.excl)
                begin
                    if (rec.qp && none_upto(rec_w, rec.xlvl))
                    begin
                        rec_w.qp = 1'b0;
                        e_fv     = 1'b1;
                        e_ft     = rec.qtag;
                    end
                end
                else if (none_upto(rec_w, LVL_W'(LEVELS - 1)))
                begin
                    e_clr   = 1'b1;
                    e_freed = 1'b1;
                end
            end
        end
        else if ((op_reg == OP_PROMOTE) && lvl_bad)
        begin
            e_code = RC_BAD;
        end
        else if (!rec.excl)
        begin
            e_code = RC_NOT_EXCL;
        end
        else if (op_reg == OP_QUIESCE)
        begin
            if (none_upto(rec, rec.xlvl))
            begin
                e_fv = 1'b1;
                e_ft = cont_reg;
            end
            else
            begin
                rec_w.qp   = 1'b1;
                rec_w.qtag = cont_reg;
                rec_we     = 1'b1;
                e_code     = RC_SHARED;
            end
        end
        else if (op_reg == OP_PROMOTE)
        begin
            rec_w.xlvl = li;
            rec_we     = 1'b1;
            e_code     = none_upto(rec, li) ? RC_GRANTED : RC_SHARED;
        end
        else
        begin
            rec_w.qp   = 1'b0;
            rec_w.pcnt = '0;
            rec_we     = 1'b1;
            e_freed    = none_upto(rec, LVL_W'(LEVELS - 1));
            if (e_freed)
            begin
                e_clr = 1'b1;
            end
            else
            begin
                rec_w.excl = 1'b0;
            end
            e_n     = (32'(rec.pcnt) > 32'(WAIT_DEPTH)) ? PC_W'(WAIT_DEPTH) : rec.pcnt;
            e_drain = (e_n != '0);
        end
        rec_we  = rec_we && cmd.exe_en;
        park_we = park_we && cmd.exe_en;
    end

    always_comb
    begin
        for (int s = 0; s < CELLS; s++)
        begin
            valid_next[s] = valid_reg[s];
        end
        if (cmd.exe_en && e_alloc)
        begin
            valid_next[slot_reg] = 1'b1;
        end
        if (cmd.exe_en && e_clr)
        begin
            valid_next[slot_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < CELLS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < CELLS; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exe_en && e_alloc)
        begin
            key_v_reg[slot_reg] <= kv_reg;
            key_d_reg[slot_reg] <= kd_reg;
            key_b_reg[slot_reg] <= kb_reg;
            key_e_reg[slot_reg] <= ke_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            didx_reg  <= '0;
            dcnt_reg  <= '0;
            freed_reg <= 1'b0;
        end
        else if (cmd.exe_en && e_drain)
        begin
            didx_reg  <= '0;
            dcnt_reg  <= e_n;
            freed_reg <= e_freed;
        end
        else if (cmd.drn_emit)
        begin
            didx_reg <= didx_reg + PC_W'(1);
        end
    end

    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.exe_drain  = e_drain;
    assign stat.drain_last = ((PC_W + 1)'(didx_reg) + (PC_W + 1)'(1)) ==
                             (PC_W + 1)'(dcnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.exe_en && !e_drain) || cmd.drn_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exe_en && !e_drain)
        begin
            code_reg   <= e_code;
            oslot_reg  <= e_slot;
            ofreed_reg <= e_freed;
            rv_reg     <= 1'b0;
            rb_reg     <= '0;
            fv_reg     <= e_fv;
            ft_reg     <= e_ft;
            last_reg   <= 1'b1;
        end
        else if (cmd.drn_emit)
        begin
            code_reg   <= RC_GRANTED;
            oslot_reg  <= SLOT_PORT_W'(slot_reg);
            ofreed_reg <= freed_reg;
            rv_reg     <= 1'b1;
            rb_reg     <= park_rdata;
            fv_reg     <= 1'b0;
            ft_reg     <= '0;
            last_reg   <= stat.drain_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_code    = code_reg;
    assign cell_slot      = oslot_reg;
    assign cell_freed     = ofreed_reg;
    assign released_valid = rv_reg;
    assign released_bio   = rb_reg;
    assign fired_valid    = fv_reg;
    assign fired_tag      = ft_reg;
    assign last           = last_reg;

    a_exe_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exe_en && !e_drain) |=> out_valid_reg)
        else $error("execute did not load a result");

    a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drn_emit |-> (didx_reg < dcnt_reg))
        else $error("drain index past count");

    a_drain_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drn_rd |-> (dcnt_reg != '0))
        else $error("drain with empty queue");

endmodule
